@@ design/char_lcd_nibble_writer_core_defines.svh @@
// Assertion macros used by the port checker file.
`ifndef CHAR_LCD_NIBBLE_WRITER_CORE_DEFINES_SVH
`define CHAR_LCD_NIBBLE_WRITER_CORE_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted.
`define LCDNW_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion, checked at every edge.
`define LCDNW_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/lcdnw_pkg.sv @@
// Types, codes and the init command table of the character LCD nibble writer.
package lcdnw_pkg;

    localparam logic [2:0] OPC_INIT   = 3'd0;
    localparam logic [2:0] OPC_CMD    = 3'd1;
    localparam logic [2:0] OPC_DATA   = 3'd2;
    localparam logic [2:0] OPC_CURSOR = 3'd3;
    localparam logic [2:0] OPC_CLEAR  = 3'd4;

    localparam logic [1:0] CFG_ENABLE_HIGH = 2'd0;
    localparam logic [1:0] CFG_ENABLE_LOW  = 2'd1;
    localparam logic [1:0] CFG_SETTLE      = 2'd2;
    localparam logic [1:0] CFG_POWER_ON    = 2'd3;

    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_ROW0_BASE = 8'h80;
    localparam logic [7:0] CMD_ROW1_BASE = 8'hC0;

    localparam logic [2:0] INIT_LAST_IDX = 3'd5;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] value;
        logic [1:0] row;
        logic [3:0] column;
    } t_in_word;

    typedef struct packed {
        logic       reg_select;
        logic       read_write;
        logic       enable;
        logic [3:0] nibble;
        logic [8:0] hold_ticks;
        logic       last;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAIT,
        ST_NIB
    } t_state;

    function automatic logic [7:0] init_cmd(input logic [2:0] idx);
        logic [7:0] cmd;
        case (idx)
            3'd0:    cmd = 8'h02;
            3'd1:    cmd = 8'h28;
            3'd2:    cmd = 8'h0C;
            3'd3:    cmd = 8'h06;
            3'd4:    cmd = 8'h01;
            3'd5:    cmd = 8'h80;
            default: cmd = 8'h00;
        endcase
        return cmd;
    endfunction

endpackage

@@ design/char_lcd_nibble_writer_core.sv @@
// Top level of the character LCD nibble writer: sequencer, digit shifter and output register.
// One word goes in per operation and each pin state comes out as one output word, at most
// one per cycle: a byte write (command, data, set cursor, clear) gives 4 words and init gives
// 25. An item is accepted only while the sequencer is idle, so a new operation is taken
// only once the last word of the one before is in the output register; the output register
// sets the pace, and the byte is shifted out one nibble at a time. Set cursor with row 2 or
// 3 and opcodes 5 to 7 give no words. Configuration writes take effect at once and are meant
// for idle periods only.
module char_lcd_nibble_writer_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  lcdnw_pkg::t_in_word  i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output lcdnw_pkg::t_out_word o_out_word
);

    logic [7:0] r_en_high;
    logic [7:0] r_en_low;
    logic [7:0] r_settle;
    logic [7:0] r_power_on;

    lcdnw_pkg::t_state    r_state, n_state;
    logic [7:0]           r_byte, n_byte;
    logic                 r_rs, n_rs;
    logic                 r_init, n_init;
    logic [2:0]           r_idx, n_idx;
    logic [1:0]           r_phase, n_phase;
    logic                 r_out_valid, n_out_valid;
    lcdnw_pkg::t_out_word r_out, n_out;

    logic in_accept;
    logic out_free;
    logic end_op;

    assign o_in_stall  = (r_state != lcdnw_pkg::ST_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en_high  <= 8'd5;
            r_en_low   <= 8'd3;
            r_settle   <= 8'd2;
            r_power_on <= 8'd5;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lcdnw_pkg::CFG_ENABLE_HIGH: r_en_high  <= i_cfg_data;
                lcdnw_pkg::CFG_ENABLE_LOW:  r_en_low   <= i_cfg_data;
                lcdnw_pkg::CFG_SETTLE:      r_settle   <= i_cfg_data;
                lcdnw_pkg::CFG_POWER_ON:    r_power_on <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lcdnw_pkg::ST_IDLE;
            r_init      <= 1'b0;
            r_idx       <= '0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init      <= n_init;
            r_idx       <= n_idx;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_rs   <= n_rs;
        r_out  <= n_out;
    end

    assign end_op = (r_phase == 2'd3) && (!r_init || r_idx == lcdnw_pkg::INIT_LAST_IDX);

    always_comb begin
        n_state     = r_state;
        n_byte      = r_byte;
        n_rs        = r_rs;
        n_init      = r_init;
        n_idx       = r_idx;
        n_phase     = r_phase;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        case (r_state)
            lcdnw_pkg::ST_IDLE: begin
                n_phase = 2'd0;
                n_idx   = 3'd0;
                n_init  = 1'b0;
                n_rs    = 1'b0;
                if (in_accept) begin
                    case (i_in_word.opcode)
                        lcdnw_pkg::OPC_INIT: begin
                            n_init  = 1'b1;
                            n_byte  = lcdnw_pkg::init_cmd(3'd0);
                            n_state = lcdnw_pkg::ST_WAIT;
                        end
                        lcdnw_pkg::OPC_CMD: begin
                            n_byte  = i_in_word.value;
                            n_state = lcdnw_pkg::ST_NIB;
                        end
                        lcdnw_pkg::OPC_DATA: begin
                            n_byte  = i_in_word.value;
                            n_rs    = 1'b1;
                            n_state = lcdnw_pkg::ST_NIB;
                        end
                        lcdnw_pkg::OPC_CURSOR: begin
                            if (i_in_word.row == 2'd0) begin
                                n_byte  = lcdnw_pkg::CMD_ROW0_BASE | {4'h0, i_in_word.column};
                                n_state = lcdnw_pkg::ST_NIB;
                            end else if (i_in_word.row == 2'd1) begin
                                n_byte  = lcdnw_pkg::CMD_ROW1_BASE | {4'h0, i_in_word.column};
                                n_state = lcdnw_pkg::ST_NIB;
                            end
                        end
                        lcdnw_pkg::OPC_CLEAR: begin
                            n_byte  = lcdnw_pkg::CMD_CLEAR;
                            n_state = lcdnw_pkg::ST_NIB;
                        end
                        default: ;
                    endcase
                end
            end
            lcdnw_pkg::ST_WAIT: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.reg_select = 1'b0;
                    n_out.read_write = 1'b0;
                    n_out.enable     = 1'b0;
                    n_out.nibble     = 4'h0;
                    n_out.hold_ticks = {1'b0, r_power_on};
                    n_out.last       = 1'b0;
                    n_state          = lcdnw_pkg::ST_NIB;
                end
            end
            lcdnw_pkg::ST_NIB: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.reg_select = r_rs;
                    n_out.read_write = 1'b0;
                    n_out.enable     = ~r_phase[0];
                    n_out.nibble     = r_byte[7:4];
                    n_out.last       = end_op;
                    case (r_phase)
                        2'd0, 2'd2: n_out.hold_ticks = {1'b0, r_en_high};
                        2'd1:       n_out.hold_ticks = {1'b0, r_en_low};
                        2'd3:       n_out.hold_ticks = {1'b0, r_en_low} + {1'b0, r_settle};
                        default:    n_out.hold_ticks = '0;
                    endcase
                    n_phase = r_phase + 2'd1;
                    // advance to the lower nibble
                    if (r_phase == 2'd1) begin
                        n_byte = {r_byte[3:0], 4'h0};
                    end
                    if (r_phase == 2'd3) begin
                        if (end_op) begin
                            n_state = lcdnw_pkg::ST_IDLE;
                        end else begin
                            n_idx  = r_idx + 3'd1;
                            n_byte = lcdnw_pkg::init_cmd(r_idx + 3'd1);
                        end
                    end
                end
            end
            default: n_state = lcdnw_pkg::ST_IDLE;
        endcase
    end

endmodule

@@ design/lcdnw_checker.sv @@
// Port-level assertions for the character LCD nibble writer and their bind.
`include "char_lcd_nibble_writer_core_defines.svh"

module lcdnw_port_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input lcdnw_pkg::t_out_word o_out_word
);

    `LCDNW_ASSERT_RST(a_out_hold, i_clk, i_rst_n,
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word),
        "stalled output word changed")

    `LCDNW_ASSERT_RST(a_rw_low, i_clk, i_rst_n,
        o_out_valid |-> !o_out_word.read_write,
        "read_write driven high")

    `LCDNW_ASSERT_RST(a_high_not_last, i_clk, i_rst_n,
        o_out_valid && o_out_word.enable |-> !o_out_word.last,
        "operation ended with enable high")

    `LCDNW_ASSERT_RST(a_no_gap, i_clk, i_rst_n,
        o_out_valid && !i_out_stall && !o_out_word.last |=> o_out_valid,
        "gap inside an operation")

endmodule

bind char_lcd_nibble_writer_core lcdnw_port_checker u_lcdnw_checker (.*);

@@ bench/lcdnw_checker.sv @@
`timescale 1ns / 1ps
// Checker for the LCD nibble writer: tracks registers, predicts pin-state words, compares.
module lcdnw_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  lcdnw_pkg::t_in_word  i_in_word,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  lcdnw_pkg::t_out_word i_out_word,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam logic [47:0] INIT_SEQ = 48'h02_28_0C_06_01_80;

    logic [7:0] en_high_t;
    logic [7:0] en_low_t;
    logic [7:0] settle_t;
    logic [7:0] power_on_t;

    lcdnw_pkg::t_out_word pin_states_q[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic push_state(input logic rs, input logic en, input logic [3:0] nib,
                              input logic [8:0] hold, input logic fin);
        lcdnw_pkg::t_out_word s;
        s.reg_select = rs;
        s.read_write = 1'b0;
        s.enable     = en;
        s.nibble     = nib;
        s.hold_ticks = hold;
        s.last       = fin;
        pin_states_q.push_back(s);
    endtask

    task automatic push_byte(input logic rs, input logic [7:0] b, input logic fin);
        push_state(rs, 1'b1, b[7:4], {1'b0, en_high_t}, 1'b0);
        push_state(rs, 1'b0, b[7:4], {1'b0, en_low_t}, 1'b0);
        push_state(rs, 1'b1, b[3:0], {1'b0, en_high_t}, 1'b0);
        push_state(rs, 1'b0, b[3:0], {1'b0, en_low_t} + {1'b0, settle_t}, fin);
    endtask

    task automatic predict_pin_states(input lcdnw_pkg::t_in_word w);
        case (w.opcode)
            lcdnw_pkg::OPC_INIT: begin
                push_state(1'b0, 1'b0, 4'h0, {1'b0, power_on_t}, 1'b0);
                for (int i = 0; i < 6; i++) begin
                    push_byte(1'b0, INIT_SEQ[47 - 8 * i -: 8], i == 5);
                end
            end
            lcdnw_pkg::OPC_CMD:  push_byte(1'b0, w.value, 1'b1);
            lcdnw_pkg::OPC_DATA: push_byte(1'b1, w.value, 1'b1);
            lcdnw_pkg::OPC_CURSOR: begin
                if (w.row == 2'd0) begin
                    push_byte(1'b0, lcdnw_pkg::CMD_ROW0_BASE | {4'h0, w.column}, 1'b1);
                end else if (w.row == 2'd1) begin
                    push_byte(1'b0, lcdnw_pkg::CMD_ROW1_BASE | {4'h0, w.column}, 1'b1);
                end
            end
            lcdnw_pkg::OPC_CLEAR: push_byte(1'b0, lcdnw_pkg::CMD_CLEAR, 1'b1);
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        lcdnw_pkg::t_out_word want_w;
        if (!i_rst_n) begin
            en_high_t  = 8'd5;
            en_low_t   = 8'd3;
            settle_t   = 8'd2;
            power_on_t = 8'd5;
            pin_states_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    lcdnw_pkg::CFG_ENABLE_HIGH: en_high_t  = i_cfg_data;
                    lcdnw_pkg::CFG_ENABLE_LOW:  en_low_t   = i_cfg_data;
                    lcdnw_pkg::CFG_SETTLE:      settle_t   = i_cfg_data;
                    lcdnw_pkg::CFG_POWER_ON:    power_on_t = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (pin_states_q.size() == 0) begin
                    $display("%0t: unexpected word, expected none, got %h", $time, i_out_word);
                    o_fail_count++;
                end else begin
                    want_w = pin_states_q.pop_front();
                    check_field("reg_select", want_w.reg_select, i_out_word.reg_select);
                    check_field("read_write", want_w.read_write, i_out_word.read_write);
                    check_field("enable", want_w.enable, i_out_word.enable);
                    check_field("nibble", want_w.nibble, i_out_word.nibble);
                    check_field("hold_ticks", want_w.hold_ticks, i_out_word.hold_ticks);
                    check_field("last", want_w.last, i_out_word.last);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_pin_states(i_in_word);
            end
        end
        o_pending = pin_states_q.size();
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the LCD nibble writer bench: clock, reset, stimulus, stall driver and verdict.
module tb_top;

    localparam int OP_TARGET = 130;
    localparam int PHASES    = 6;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [1:0]           i_cfg_index;
    logic [7:0]           i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    lcdnw_pkg::t_in_word  i_in_word;
    logic                 o_out_valid;
    logic                 i_out_stall;
    lcdnw_pkg::t_out_word o_out_word;

    int fail_count;
    int pending;
    bit calm;
    int quiet_items;
    int op_count;

    char_lcd_nibble_writer_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    lcdnw_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_word    (i_in_word),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_word   (o_out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("char_lcd_nibble_writer_core verification failed");
        $finish;
    end

    initial begin
        i_out_stall = 1'b0;
        forever begin
            if (!calm && $urandom_range(0, 1) == 1) begin
                repeat ($urandom_range(20, 80)) begin
                    @(negedge i_clk);
                    if (!calm && $urandom_range(0, 5) == 0) begin
                        i_out_stall = 1'b1;
                        repeat ($urandom_range(1, 17)) @(negedge i_clk);
                        i_out_stall = 1'b0;
                    end
                end
            end else begin
                repeat ($urandom_range(20, 80)) @(negedge i_clk);
            end
        end
    end

    function automatic lcdnw_pkg::t_in_word op_word(input logic [2:0] opc,
                                                    input logic [7:0] val,
                                                    input logic [1:0] r,
                                                    input logic [3:0] c);
        lcdnw_pkg::t_in_word w;
        w.opcode = opc;
        w.value  = val;
        w.row    = r;
        w.column = c;
        return w;
    endfunction

    function automatic bit makes_words(input lcdnw_pkg::t_in_word w);
        if (w.opcode == lcdnw_pkg::OPC_CURSOR) return w.row < 2'd2;
        return w.opcode <= lcdnw_pkg::OPC_CLEAR;
    endfunction

    function automatic lcdnw_pkg::t_in_word rand_word();
        lcdnw_pkg::t_in_word w;
        int r;
        r = $urandom_range(0, 99);
        w.value  = 8'($urandom_range(0, 255));
        w.row    = 2'($urandom_range(0, 3));
        w.column = 4'($urandom_range(0, 15));
        if (r < 6) begin
            w.opcode = lcdnw_pkg::OPC_INIT;
        end else if (r < 34) begin
            w.opcode = lcdnw_pkg::OPC_CMD;
        end else if (r < 62) begin
            w.opcode = lcdnw_pkg::OPC_DATA;
        end else if (r < 82) begin
            w.opcode = lcdnw_pkg::OPC_CURSOR;
            w.row    = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(2, 3))
                                                  : 2'($urandom_range(0, 1));
        end else if (r < 92) begin
            w.opcode = lcdnw_pkg::OPC_CLEAR;
        end else begin
            w.opcode = lcdnw_pkg::OPC_CLEAR + 3'd1 + 3'($urandom_range(0, 2));
        end
        return w;
    endfunction

    function automatic logic [7:0] pick_ticks();
        case ($urandom_range(0, 4))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_op(input lcdnw_pkg::t_in_word w);
        if (quiet_items > 0) begin
            quiet_items--;
        end else if ($urandom_range(0, 19) == 0) begin
            quiet_items = $urandom_range(5, 20);
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_word  = w;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    task automatic apply_config(input logic [7:0] hi_t, input logic [7:0] lo_t,
                                input logic [7:0] st_t, input logic [7:0] po_t);
        write_reg(lcdnw_pkg::CFG_ENABLE_HIGH, hi_t);
        write_reg(lcdnw_pkg::CFG_ENABLE_LOW, lo_t);
        write_reg(lcdnw_pkg::CFG_SETTLE, st_t);
        write_reg(lcdnw_pkg::CFG_POWER_ON, po_t);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        calm        = 1'b0;
        quiet_items = 0;
        op_count    = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        send_op(op_word(lcdnw_pkg::OPC_INIT, 8'h00, 2'd0, 4'h0));
        send_op(op_word(lcdnw_pkg::OPC_CMD, 8'h00, 2'd3, 4'hF));
        send_op(op_word(lcdnw_pkg::OPC_CMD, 8'hFF, 2'd0, 4'h0));
        send_op(op_word(lcdnw_pkg::OPC_DATA, 8'hA5, 2'd1, 4'h5));
        send_op(op_word(lcdnw_pkg::OPC_DATA, 8'h5A, 2'd2, 4'hA));
        send_op(op_word(lcdnw_pkg::OPC_CURSOR, 8'hFF, 2'd0, 4'h0));
        send_op(op_word(lcdnw_pkg::OPC_CURSOR, 8'h00, 2'd0, 4'hF));
        send_op(op_word(lcdnw_pkg::OPC_CURSOR, 8'h00, 2'd1, 4'h0));
        send_op(op_word(lcdnw_pkg::OPC_CURSOR, 8'hFF, 2'd1, 4'hF));
        send_op(op_word(lcdnw_pkg::OPC_CURSOR, 8'h00, 2'd2, 4'h7));
        send_op(op_word(lcdnw_pkg::OPC_CURSOR, 8'hFF, 2'd3, 4'hF));
        send_op(op_word(lcdnw_pkg::OPC_CLEAR, 8'hFF, 2'd3, 4'hF));
        for (int k = lcdnw_pkg::OPC_CLEAR + 1; k < 8; k++) begin
            send_op(op_word(3'(k), 8'hFF, 2'd3, 4'hF));
        end

        drain();
        apply_config(8'h00, 8'h00, 8'h00, 8'h00);
        send_op(op_word(lcdnw_pkg::OPC_INIT, 8'hFF, 2'd3, 4'hF));
        send_op(op_word(lcdnw_pkg::OPC_DATA, 8'hFF, 2'd0, 4'h0));
        send_op(op_word(lcdnw_pkg::OPC_CURSOR, 8'h00, 2'd1, 4'hF));

        drain();
        apply_config(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_op(op_word(lcdnw_pkg::OPC_CMD, 8'h00, 2'd0, 4'h0));
        send_op(op_word(lcdnw_pkg::OPC_INIT, 8'h00, 2'd0, 4'h0));
        send_op(op_word(lcdnw_pkg::OPC_CLEAR, 8'h00, 2'd0, 4'h0));

        for (int p = 0; p < PHASES; p++) begin : phase
            lcdnw_pkg::t_in_word w;
            drain();
            if (p == PHASES - 1) calm = 1'b1;
            apply_config(pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks());
            while (op_count < (p + 1) * OP_TARGET / PHASES) begin
                w = rand_word();
                send_op(w);
                if (makes_words(w)) op_count++;
            end
        end

        drain();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("char_lcd_nibble_writer_core verification clean");
        end else begin
            $display("char_lcd_nibble_writer_core verification failed");
        end
        $finish;
    end

endmodule
